@@ design/wam_pkg.sv @@
// Shared types, codes and limit constants for the window alarm block.
package wam_pkg;

    // Limit field width and clamp ceiling
    localparam int LimitW = 7;
    localparam logic [LimitW-1:0] LIMIT_CEILING = 7'd99;

    // Reset values of the limits
    localparam logic [LimitW-1:0] TEMP_HIGH_RESET  = 7'd40;
    localparam logic [LimitW-1:0] TEMP_LOW_RESET   = 7'd10;
    localparam logic [LimitW-1:0] HUMID_HIGH_RESET = 7'd60;
    localparam logic [LimitW-1:0] HUMID_LOW_RESET  = 7'd12;

    // Alternation counter: last step before wrap, and blank steps
    localparam logic [2:0] ALT_LAST  = 3'd6;
    localparam logic [2:0] ALT_BLANK = 3'd3;

    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_UP     = 2'd1,
        REQ_DOWN   = 2'd2,
        REQ_SAMPLE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        MENU_RUN        = 3'd0,
        MENU_TEMP_HIGH  = 3'd1,
        MENU_TEMP_LOW   = 3'd2,
        MENU_HUMID_HIGH = 3'd3,
        MENU_HUMID_LOW  = 3'd4
    } menu_t;

    typedef enum logic [2:0] {
        MSG_NONE    = 3'd0,
        MSG_NORMAL  = 3'd1,
        MSG_TEMP    = 3'd2,
        MSG_HUMID   = 3'd3,
        MSG_BLANK   = 3'd4
    } msg_t;

    // Persistent block state
    typedef struct packed {
        menu_t             menu;
        logic [LimitW-1:0] temp_high;
        logic [LimitW-1:0] temp_low;
        logic [LimitW-1:0] humid_high;
        logic [LimitW-1:0] humid_low;
        logic              temp_alert;
        logic              humid_alarm;
        logic [2:0]        alt_count;
        logic              buzzer;
    } state_t;

    // One result word, last field in the lowest bits
    typedef struct packed {
        msg_t              message;
        logic              key_chirp;
        logic              buzzer_on;
        logic              humid_alarm;
        logic              temp_alert;
        logic [LimitW-1:0] humid_low;
        logic [LimitW-1:0] humid_high;
        logic [LimitW-1:0] temp_low;
        logic [LimitW-1:0] temp_high;
        menu_t             menu_pos;
    } result_t;

    // One input item
    typedef struct packed {
        req_t       req;
        logic [7:0] temp;
        logic [7:0] humid;
    } item_t;

endpackage

@@ design/wam_update.sv @@
// Next-state and result logic for one key or sample event.
module wam_update (
    input  wam_pkg::state_t  st,
    input  wam_pkg::item_t   item,
    output wam_pkg::state_t  st_next,
    output wam_pkg::result_t res
);

    logic             chirp;
    wam_pkg::msg_t    msg;
    logic             t_alarm;
    logic             h_alarm;
    logic [2:0]       alt_inc;

    // Window compare at or past either limit
    assign t_alarm = (item.temp <= {1'b0, st.temp_low}) ||
                     (item.temp >= {1'b0, st.temp_high});
    assign h_alarm = (item.humid <= {1'b0, st.humid_low}) ||
                     (item.humid >= {1'b0, st.humid_high});
    assign alt_inc = (st.alt_count >= wam_pkg::ALT_LAST) ? 3'd0 : st.alt_count + 3'd1;

    // Apply the event to the state
    always_comb begin
        st_next = st;
        chirp   = 1'b0;
        msg     = wam_pkg::MSG_NONE;
        unique case (item.req)
            wam_pkg::REQ_SET: begin
                chirp = 1'b1;
                unique case (st.menu)
                    wam_pkg::MENU_RUN:        st_next.menu = wam_pkg::MENU_TEMP_HIGH;
                    wam_pkg::MENU_TEMP_HIGH:  st_next.menu = wam_pkg::MENU_TEMP_LOW;
                    wam_pkg::MENU_TEMP_LOW:   st_next.menu = wam_pkg::MENU_HUMID_HIGH;
                    wam_pkg::MENU_HUMID_HIGH: st_next.menu = wam_pkg::MENU_HUMID_LOW;
                    default:                  st_next.menu = wam_pkg::MENU_RUN;
                endcase
            end
            wam_pkg::REQ_UP: begin
                chirp = (st.menu != wam_pkg::MENU_RUN);
                unique case (st.menu)
                    wam_pkg::MENU_TEMP_HIGH:
                        if (st.temp_high < wam_pkg::LIMIT_CEILING)
                            st_next.temp_high = st.temp_high + 7'd1;
                    wam_pkg::MENU_TEMP_LOW:
                        if (st.temp_low < st.temp_high)
                            st_next.temp_low = st.temp_low + 7'd1;
                    wam_pkg::MENU_HUMID_HIGH:
                        if (st.humid_high < wam_pkg::LIMIT_CEILING)
                            st_next.humid_high = st.humid_high + 7'd1;
                    wam_pkg::MENU_HUMID_LOW:
                        if (st.humid_low < st.humid_high)
                            st_next.humid_low = st.humid_low + 7'd1;
                    default: ;
                endcase
            end
            wam_pkg::REQ_DOWN: begin
                chirp = (st.menu != wam_pkg::MENU_RUN);
                unique case (st.menu)
                    wam_pkg::MENU_TEMP_HIGH:
                        if (st.temp_high > st.temp_low)
                            st_next.temp_high = st.temp_high - 7'd1;
                    wam_pkg::MENU_TEMP_LOW:
                        if (st.temp_low != 7'd0)
                            st_next.temp_low = st.temp_low - 7'd1;
                    wam_pkg::MENU_HUMID_HIGH:
                        if (st.humid_high > st.humid_low)
                            st_next.humid_high = st.humid_high - 7'd1;
                    wam_pkg::MENU_HUMID_LOW:
                        if (st.humid_low != 7'd0)
                            st_next.humid_low = st.humid_low - 7'd1;
                    default: ;
                endcase
            end
            default: begin
                // Evaluate a sample in run mode only
                if (st.menu == wam_pkg::MENU_RUN) begin
                    st_next.temp_alert  = t_alarm;
                    st_next.humid_alarm = h_alarm;
                    st_next.buzzer      = t_alarm | h_alarm;
                    if (t_alarm && h_alarm) begin
                        st_next.alt_count = alt_inc;
                        if (alt_inc <= 3'd2)
                            msg = wam_pkg::MSG_TEMP;
                        else if (alt_inc == wam_pkg::ALT_BLANK)
                            msg = wam_pkg::MSG_BLANK;
                        else if (alt_inc < wam_pkg::ALT_LAST)
                            msg = wam_pkg::MSG_HUMID;
                        else
                            msg = wam_pkg::MSG_BLANK;
                    end else begin
                        st_next.alt_count = 3'd0;
                        if (t_alarm)
                            msg = wam_pkg::MSG_TEMP;
                        else if (h_alarm)
                            msg = wam_pkg::MSG_HUMID;
                        else
                            msg = wam_pkg::MSG_NORMAL;
                    end
                end
            end
        endcase
        // Drop the buzzer after an accepted key
        if (chirp)
            st_next.buzzer = 1'b0;
    end

    // Assemble the result word from the new state
    always_comb begin
        res.menu_pos    = st_next.menu;
        res.temp_high   = st_next.temp_high;
        res.temp_low    = st_next.temp_low;
        res.humid_high  = st_next.humid_high;
        res.humid_low   = st_next.humid_low;
        res.temp_alert  = st_next.temp_alert;
        res.humid_alarm = st_next.humid_alarm;
        res.buzzer_on   = st_next.buzzer;
        res.key_chirp   = chirp;
        res.message     = msg;
    end

endmodule

@@ design/window_alarm_with_limit_menu.sv @@
// Top level of the window alarm with limit-setting menu.
//
//  channel | dir | tdata fields (low bit up)                        | tuser
//  s_      | in  | temp_sample[7:0], humid_sample[15:8]             | req_type[1:0]
//  m_      | out | menu_pos[2:0], temp_high[9:3], temp_low[16:10],   | none
//          |     | humid_high[23:17], humid_low[30:24], temp_alert, |
//          |     | humid_alarm, buzzer_on, key_chirp, message[37:35]|
//
// Each word passes an input register, then the update logic, into the result register:
// one word a cycle while the result channel does not stall.
// The limits, menu and alarm state change when a word leaves the input register.
// Reset (aresetn low, synchronous) empties both registers and loads default limits.
// A stalled result holds the update stage; the input register takes one more word,
// then s_tready drops until the result word leaves.
module window_alarm_with_limit_menu (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // temp_sample[7:0], humid_sample[15:8]
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // menu_pos, temp_high, temp_low, humid_high,
                                  // humid_low, temp_alert, humid_alarm,
                                  // buzzer_on, key_chirp, message, zero pad
);

    logic              in_valid_reg;
    wam_pkg::item_t    in_item_reg;
    logic              out_valid_reg;
    wam_pkg::result_t  out_res_reg;
    wam_pkg::state_t   st_reg;
    wam_pkg::state_t   st_next;
    wam_pkg::result_t  res_next;
    logic              advance;

    // Move a word into the result register when it is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    wam_update u_update (
        .st      (st_reg),
        .item    (in_item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_item_reg.req   <= wam_pkg::req_t'(s_tuser);
            in_item_reg.temp  <= s_tdata[7:0];
            in_item_reg.humid <= s_tdata[15:8];
        end
    end

    // Block state: advance with each word that leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.menu        <= wam_pkg::MENU_RUN;
            st_reg.temp_high   <= wam_pkg::TEMP_HIGH_RESET;
            st_reg.temp_low    <= wam_pkg::TEMP_LOW_RESET;
            st_reg.humid_high  <= wam_pkg::HUMID_HIGH_RESET;
            st_reg.humid_low   <= wam_pkg::HUMID_LOW_RESET;
            st_reg.temp_alert  <= 1'b0;
            st_reg.humid_alarm <= 1'b0;
            st_reg.alt_count   <= 3'd0;
            st_reg.buzzer      <= 1'b0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance)
            out_res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

`ifndef NO_ASSERTIONS
    // Limits keep their order and ceiling
    a_temp_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.temp_low <= st_reg.temp_high) &&
        (st_reg.temp_high <= wam_pkg::LIMIT_CEILING))
        else $error("temperature limits out of order");
    a_humid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.humid_low <= st_reg.humid_high) &&
        (st_reg.humid_high <= wam_pkg::LIMIT_CEILING))
        else $error("humidity limits out of order");
    // Alternation counter stays within its seven steps
    a_alt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.alt_count <= wam_pkg::ALT_LAST)
        else $error("alternation counter out of range");
    // A chirp result always carries the buzzer off and no message
    a_chirp_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.key_chirp) |->
        (!out_res_reg.buzzer_on && out_res_reg.message == wam_pkg::MSG_NONE))
        else $error("chirp with buzzer or message");
    // State changes only when a word advances
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!advance) |=> $stable(st_reg))
        else $error("state changed without a word");
`endif

endmodule

@@ verif/window_alarm_checker.sv @@
`timescale 1ns / 1ps
// Channel monitor for the window alarm block: predicts each result word and compares it.
module window_alarm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // temp_sample[7:0], humid_sample[15:8]
    input  logic [1:0]  s_tuser,    // req_type[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // menu_pos, limits, alarms, buzzer, chirp, message
    output int          fail_count,
    output int          outstanding
);

    // Predicted block state
    wam_pkg::menu_t             menu_sel;
    logic [wam_pkg::LimitW-1:0] temp_hi;
    logic [wam_pkg::LimitW-1:0] temp_lo;
    logic [wam_pkg::LimitW-1:0] humid_hi;
    logic [wam_pkg::LimitW-1:0] humid_lo;
    logic                       temp_alm;
    logic                       humid_alm;
    logic                       buzz;
    logic [2:0]                 alt_step;

    wam_pkg::result_t expected_words[$];
    int               mismatches = 0;
    int               words_due  = 0;

    assign fail_count  = mismatches;
    assign outstanding = words_due;

    task automatic report_mismatch(input string what, input logic [39:0] want_v,
                                   input logic [39:0] got_v);
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            report_mismatch(what, 40'(want_v), 40'(got_v));
        end
    endtask

    // Apply one event to the predicted state and build the word it should produce
    function automatic wam_pkg::result_t next_window_result(wam_pkg::req_t req,
                                                            logic [7:0] temp,
                                                            logic [7:0] humid);
        wam_pkg::result_t r;
        logic             chirp;
        wam_pkg::msg_t    msg;
        chirp = 1'b0;
        msg   = wam_pkg::MSG_NONE;
        case (req)
            wam_pkg::REQ_SET: begin
                chirp    = 1'b1;
                menu_sel = (menu_sel == wam_pkg::MENU_HUMID_LOW) ? wam_pkg::MENU_RUN
                                                                 : wam_pkg::menu_t'(menu_sel + 3'd1);
            end
            wam_pkg::REQ_UP: begin
                if (menu_sel != wam_pkg::MENU_RUN) begin
                    chirp = 1'b1;
                    case (menu_sel)
                        wam_pkg::MENU_TEMP_HIGH:
                            if (temp_hi < wam_pkg::LIMIT_CEILING) temp_hi++;
                        wam_pkg::MENU_TEMP_LOW:
                            if (temp_lo < temp_hi) temp_lo++;
                        wam_pkg::MENU_HUMID_HIGH:
                            if (humid_hi < wam_pkg::LIMIT_CEILING) humid_hi++;
                        default:
                            if (humid_lo < humid_hi) humid_lo++;
                    endcase
                end
            end
            wam_pkg::REQ_DOWN: begin
                if (menu_sel != wam_pkg::MENU_RUN) begin
                    chirp = 1'b1;
                    case (menu_sel)
                        wam_pkg::MENU_TEMP_HIGH:  if (temp_hi > temp_lo) temp_hi--;
                        wam_pkg::MENU_TEMP_LOW:   if (temp_lo > 0) temp_lo--;
                        wam_pkg::MENU_HUMID_HIGH: if (humid_hi > humid_lo) humid_hi--;
                        default:                  if (humid_lo > 0) humid_lo--;
                    endcase
                end
            end
            default: begin
                // Evaluate samples in run mode only; menu samples change nothing
                if (menu_sel == wam_pkg::MENU_RUN) begin
                    temp_alm  = (temp <= temp_lo) || (temp >= temp_hi);
                    humid_alm = (humid <= humid_lo) || (humid >= humid_hi);
                    if (temp_alm && humid_alm) begin
                        alt_step = (alt_step == wam_pkg::ALT_LAST) ? 3'd0 : alt_step + 3'd1;
                        if (alt_step < wam_pkg::ALT_BLANK)
                            msg = wam_pkg::MSG_TEMP;
                        else if (alt_step == wam_pkg::ALT_BLANK ||
                                 alt_step == wam_pkg::ALT_LAST)
                            msg = wam_pkg::MSG_BLANK;
                        else
                            msg = wam_pkg::MSG_HUMID;
                    end else begin
                        alt_step = 3'd0;
                        msg = temp_alm ? wam_pkg::MSG_TEMP
                                       : (humid_alm ? wam_pkg::MSG_HUMID : wam_pkg::MSG_NORMAL);
                    end
                    buzz = temp_alm | humid_alm;
                end
            end
        endcase
        // An accepted key always leaves the buzzer off
        if (chirp) begin
            buzz = 1'b0;
        end
        r.menu_pos    = menu_sel;
        r.temp_high   = temp_hi;
        r.temp_low    = temp_lo;
        r.humid_high  = humid_hi;
        r.humid_low   = humid_lo;
        r.temp_alert  = temp_alm;
        r.humid_alarm = humid_alm;
        r.buzzer_on   = buzz;
        r.key_chirp   = chirp;
        r.message     = msg;
        return r;
    endfunction

    // Compare outgoing words first, then record the prediction for an incoming word
    always @(posedge aclk) begin : watch_channels
        wam_pkg::result_t got;
        wam_pkg::result_t want;
        if (!aresetn) begin
            menu_sel  = wam_pkg::MENU_RUN;
            temp_hi   = wam_pkg::TEMP_HIGH_RESET;
            temp_lo   = wam_pkg::TEMP_LOW_RESET;
            humid_hi  = wam_pkg::HUMID_HIGH_RESET;
            humid_lo  = wam_pkg::HUMID_LOW_RESET;
            temp_alm  = 1'b0;
            humid_alm = 1'b0;
            buzz      = 1'b0;
            alt_step  = 3'd0;
            expected_words.delete();
            words_due <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = wam_pkg::result_t'(m_tdata[37:0]);
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected result word", 40'd0, m_tdata);
                end else begin
                    want = expected_words.pop_front();
                    check_field("menu_pos", 8'(want.menu_pos), 8'(got.menu_pos));
                    check_field("temp_high", 8'(want.temp_high), 8'(got.temp_high));
                    check_field("temp_low", 8'(want.temp_low), 8'(got.temp_low));
                    check_field("humid_high", 8'(want.humid_high), 8'(got.humid_high));
                    check_field("humid_low", 8'(want.humid_low), 8'(got.humid_low));
                    check_field("temp_alert", 8'(want.temp_alert), 8'(got.temp_alert));
                    check_field("humid_alarm", 8'(want.humid_alarm), 8'(got.humid_alarm));
                    check_field("buzzer_on", 8'(want.buzzer_on), 8'(got.buzzer_on));
                    check_field("key_chirp", 8'(want.key_chirp), 8'(got.key_chirp));
                    check_field("message", 8'(want.message), 8'(got.message));
                    check_field("pad bits", 8'd0, 8'(m_tdata[39:38]));
                end
            end
            if (s_tvalid && s_tready) begin
                expected_words.push_back(next_window_result(wam_pkg::req_t'(s_tuser),
                                                            s_tdata[7:0], s_tdata[15:8]));
            end
            words_due <= expected_words.size();
        end
    end

endmodule

@@ verif/window_alarm_with_limit_menu_tb.sv @@
`timescale 1ns / 1ps
// Top of the window alarm testbench: clock, reset, key and sample stimulus, and verdict.
module window_alarm_with_limit_menu_tb;

    localparam int ITEMS         = 1350;
    localparam int TAIL_ITEMS    = 150;
    localparam int HOLD_START    = 300;
    localparam int HOLD_CLOCKS   = 250;
    localparam int SETTLE_CLOCKS = 8;
    localparam int CYCLE_LIMIT   = 200000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;

    int fail_count;
    int outstanding;
    int cycle_count  = 0;
    int useful_words = 0;
    int menu_idx     = wam_pkg::MENU_RUN;
    bit tail_phase   = 1'b0;

    window_alarm_with_limit_menu DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    window_alarm_checker watcher (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one word, with an occasional idle burst ahead of it, and wait for acceptance
    task automatic send_word(input wam_pkg::req_t req, input logic [7:0] temp,
                             input logic [7:0] humid);
        if (!tail_phase && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {humid, temp};
        do @(posedge aclk); while (!s_tready);
        // Track the menu to shape later stimulus; ignored words do not count
        if (req == wam_pkg::REQ_SET) begin
            useful_words++;
            menu_idx = (menu_idx == wam_pkg::MENU_HUMID_LOW) ? wam_pkg::MENU_RUN : menu_idx + 1;
        end else if ((req == wam_pkg::REQ_SAMPLE) == (menu_idx == wam_pkg::MENU_RUN)) begin
            useful_words++;
        end
    endtask

    task automatic go_to_menu(input wam_pkg::menu_t target);
        while (menu_idx != target) begin
            send_word(wam_pkg::REQ_SET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly readings near the limit range, some over the whole byte
    function automatic logic [7:0] pick_reading();
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(0, 105));
    endfunction

    // Receiver: random stalls, one long hold-off early on, none in the tail
    initial begin : receiver
        int stretch;
        int clocks;
        bit held;
        clocks = 0;
        held   = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held && clocks >= HOLD_START) begin
                m_tready <= 1'b0;
                repeat (HOLD_CLOCKS) @(posedge aclk);
                clocks += HOLD_CLOCKS;
                held = 1'b1;
            end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                stretch = $urandom_range(1, 12);
                repeat (stretch) @(posedge aclk);
                clocks += stretch;
            end
            m_tready <= 1'b1;
            stretch = $urandom_range(1, 30);
            repeat (stretch) @(posedge aclk);
            clocks += stretch;
        end
    end

    initial begin : stimulus
        int            kind;
        int            burst;
        wam_pkg::req_t dir;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: limit edges, alternation through a full wrap, ignored words, menu walk
        send_word(wam_pkg::REQ_SAMPLE, 8'd20, 8'd30);
        send_word(wam_pkg::REQ_SAMPLE, 8'd40, 8'd30);
        send_word(wam_pkg::REQ_SAMPLE, 8'd10, 8'd30);
        send_word(wam_pkg::REQ_SAMPLE, 8'd20, 8'd60);
        send_word(wam_pkg::REQ_SAMPLE, 8'd20, 8'd12);
        send_word(wam_pkg::REQ_SAMPLE, 8'h00, 8'h00);
        send_word(wam_pkg::REQ_SAMPLE, 8'hFF, 8'hFF);
        send_word(wam_pkg::REQ_SAMPLE, 8'hFF, 8'h00);
        send_word(wam_pkg::REQ_SAMPLE, 8'h00, 8'hFF);
        send_word(wam_pkg::REQ_SAMPLE, 8'hAA, 8'h55);
        send_word(wam_pkg::REQ_SAMPLE, 8'h55, 8'hAA);
        send_word(wam_pkg::REQ_SAMPLE, 8'd99, 8'd99);
        send_word(wam_pkg::REQ_UP, 8'h5A, 8'hA5);
        send_word(wam_pkg::REQ_DOWN, 8'hA5, 8'h5A);
        send_word(wam_pkg::REQ_SET, 8'h00, 8'hFF);
        send_word(wam_pkg::REQ_UP, 8'd0, 8'd0);
        send_word(wam_pkg::REQ_DOWN, 8'd0, 8'd0);
        send_word(wam_pkg::REQ_SAMPLE, 8'hFF, 8'hFF);
        send_word(wam_pkg::REQ_SET, 8'd0, 8'd0);
        send_word(wam_pkg::REQ_DOWN, 8'd0, 8'd0);
        send_word(wam_pkg::REQ_UP, 8'd0, 8'd0);
        send_word(wam_pkg::REQ_SET, 8'd0, 8'd0);
        send_word(wam_pkg::REQ_UP, 8'd0, 8'd0);
        send_word(wam_pkg::REQ_SET, 8'd0, 8'd0);
        send_word(wam_pkg::REQ_DOWN, 8'd0, 8'd0);
        go_to_menu(wam_pkg::MENU_RUN);
        send_word(wam_pkg::REQ_SAMPLE, 8'd21, 8'd41);

        // Random: sample bursts in run mode, limit adjust runs, and noise
        while (useful_words < ITEMS) begin
            tail_phase = (useful_words >= ITEMS - TAIL_ITEMS);
            kind = $urandom_range(0, 19);
            if (kind < 10) begin
                go_to_menu(wam_pkg::MENU_RUN);
                burst = $urandom_range(1, 20);
                repeat (burst) send_word(wam_pkg::REQ_SAMPLE, pick_reading(), pick_reading());
            end else if (kind < 17) begin
                go_to_menu(wam_pkg::menu_t'($urandom_range(wam_pkg::MENU_TEMP_HIGH,
                                                           wam_pkg::MENU_HUMID_LOW)));
                dir   = $urandom_range(0, 1) ? wam_pkg::REQ_UP : wam_pkg::REQ_DOWN;
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 110)
                                                    : $urandom_range(1, 12);
                repeat (burst) begin
                    if ($urandom_range(0, 9) == 0)
                        send_word((dir == wam_pkg::REQ_UP) ? wam_pkg::REQ_DOWN : wam_pkg::REQ_UP,
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    else
                        send_word(dir, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
            end else begin
                burst = $urandom_range(1, 5);
                repeat (burst) send_word(wam_pkg::req_t'($urandom_range(0, 3)),
                                         8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 255)));
            end
        end
        s_tvalid <= 1'b0;

        // Drain the result channel, then let the pipeline settle
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CLOCKS) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ window_alarm_with_limit_menu.f @@
design/wam_pkg.sv
design/wam_update.sv
design/window_alarm_with_limit_menu.sv
verif/window_alarm_checker.sv
verif/window_alarm_with_limit_menu_tb.sv
